>>> hw/rtl/imss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IUPAC motif site scanner package
// Base classes, register indexes, cell interface types and the per-base
// classify / complement / mask-accept functions shared by the scanner.
// ----------------------------------------------------------------------------
package imss_pkg;

  typedef logic [2:0] cls_t;
  typedef logic [4:0] mask_t;

  localparam cls_t CLS_A     = 3'd0;
  localparam cls_t CLS_C     = 3'd1;
  localparam cls_t CLS_G     = 3'd2;
  localparam cls_t CLS_T     = 3'd3;
  localparam cls_t CLS_N     = 3'd4;
  localparam cls_t CLS_OTHER = 3'd5;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 40;
  localparam int LEN_BITS       = 5;
  localparam int SITE_BITS      = 32;
  localparam int POS_BITS       = 7;

  localparam logic [CFG_INDEX_BITS-1:0] REG_MOTIF_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_STRAND_MODE  = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_FIRST = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REGION_LAST  = 3'd5;

  localparam logic [1:0] STRAND_BOTH  = 2'd0;
  localparam logic [1:0] STRAND_PLUS  = 2'd1;
  localparam logic [1:0] STRAND_MINUS = 2'd2;

  typedef struct packed {
    logic  active;
    mask_t plus_mask;
    mask_t minus_mask;
  } cell_sel_t;

  typedef struct packed {
    logic plus_ok;
    logic minus_ok;
  } cell_match_t;

  function automatic cls_t classify(input logic [7:0] ch);
    logic [7:0] up;
    up = ch;
    // fold lower case onto upper case
    if (ch >= 8'h61 && ch <= 8'h7a) up = ch - 8'h20;
    case (up)
      8'h41:   return CLS_A;
      8'h43:   return CLS_C;
      8'h47:   return CLS_G;
      8'h54:   return CLS_T;
      8'h4e:   return CLS_N;
      default: return CLS_OTHER;
    endcase
  endfunction

  function automatic cls_t complement(input cls_t cls);
    if (cls <= CLS_T) return CLS_T - cls;
    return cls;
  endfunction

  function automatic logic accepts(input mask_t mask, input cls_t cls);
    if (cls > CLS_N) return 1'b0;
    return mask[cls];
  endfunction

  // positions 16 and up have an empty mask
  function automatic mask_t pos_mask(input logic [CFG_DATA_BITS-1:0] lo,
                                     input logic [CFG_DATA_BITS-1:0] hi,
                                     input logic [POS_BITS-1:0] pos);
    logic [5:0] sh;
    sh = 6'(pos[2:0]) * 6'd5;
    if (pos < 7'd8) return mask_t'(lo >> sh);
    if (pos < 7'd16) return mask_t'(hi >> sh);
    return '0;
  endfunction

endpackage

>>> hw/rtl/iupac_motif_site_scanner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IUPAC motif site scanner
// A site passes the hold stage and then the output stage before it is offered.
// Throughput: one base per cycle while out_ready is high and each base yields
//   at most one site; a two-strand hit holds the output until both are taken.
// The window compare runs across the cell chain in the accept cycle.
// Reset (synchronous): clears registers to defaults, window, fill and queue.
// ----------------------------------------------------------------------------
module iupac_motif_site_scanner_top #(
  parameter int MAX_MOTIF  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [imss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [imss_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          base_char,
  input  logic                                restart,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [imss_pkg::SITE_BITS-1:0]      site_start,
  output logic [imss_pkg::SITE_BITS-1:0]      site_end,
  output logic                                on_minus,
  output logic                                last_of_run
);

  localparam int FILL_BITS = $clog2(MAX_MOTIF + 1);
  localparam int CW        = (COORD_BITS > 32) ? COORD_BITS : 32;
  localparam int LB        = imss_pkg::LEN_BITS;
  localparam int PB        = imss_pkg::POS_BITS;
  localparam int SB        = imss_pkg::SITE_BITS;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // configuration registers
  logic [LB-1:0]                        motif_length;
  logic [imss_pkg::CFG_DATA_BITS-1:0]   pattern_low;
  logic [imss_pkg::CFG_DATA_BITS-1:0]   pattern_high;
  logic [1:0]                           strand_mode;
  logic [31:0]                          region_first;
  logic [31:0]                          region_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      motif_length <= LB'(1);
      pattern_low  <= '0;
      pattern_high <= '0;
      strand_mode  <= imss_pkg::STRAND_BOTH;
      region_first <= 32'd1;
      region_last  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        imss_pkg::REG_MOTIF_LENGTH: motif_length <= cfg_data[LB-1:0];
        imss_pkg::REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        imss_pkg::REG_PATTERN_HIGH: pattern_high <= cfg_data;
        imss_pkg::REG_STRAND_MODE:  strand_mode  <= cfg_data[1:0];
        imss_pkg::REG_REGION_FIRST: region_first <= cfg_data[31:0];
        imss_pkg::REG_REGION_LAST:  region_last  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // effective motif length, clamped to 1..MAX_MOTIF
  logic [LB-1:0] eff_len;
  always_comb begin
    if (motif_length == '0) begin
      eff_len = LB'(1);
    end else if (32'(motif_length) > MAX_MOTIF) begin
      eff_len = LB'(MAX_MOTIF);
    end else begin
      eff_len = motif_length;
    end
  end

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // fill count and coordinates
  logic [FILL_BITS-1:0]  fill_count;
  logic [FILL_BITS-1:0]  fill_count_next;
  logic [COORD_BITS-1:0] next_position;
  logic [COORD_BITS-1:0] coord;
  logic [COORD_BITS-1:0] start;
  logic [COORD_BITS-1:0] len_m1;
  logic                  window_full;
  logic                  region_ok;

  always_comb begin
    if (restart) begin
      fill_count_next = FILL_BITS'(1);
    end else if (32'(fill_count) < MAX_MOTIF) begin
      fill_count_next = fill_count + FILL_BITS'(1);
    end else begin
      fill_count_next = fill_count;
    end
    coord       = restart ? COORD_BITS'(region_first) : next_position;
    len_m1      = COORD_BITS'(eff_len - LB'(1));
    start       = (coord >= len_m1) ? coord - len_m1 : '0;
    window_full = 32'(fill_count_next) >= 32'(eff_len);
    region_ok   = (region_last == '0) || (CW'(start) <= CW'(region_last));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      next_position <= '0;
    end else if (in_fire) begin
      fill_count    <= fill_count_next;
      // saturate at the top coordinate
      next_position <= (coord != COORD_MAX) ? coord + COORD_BITS'(1) : coord;
    end
  end

  // cell chain: slot 0 is the newest base
  imss_pkg::cls_t        cls_in;
  imss_pkg::cls_t        win   [MAX_MOTIF];
  imss_pkg::cell_sel_t   sel   [MAX_MOTIF];
  imss_pkg::cell_match_t match [MAX_MOTIF];

  assign cls_in = imss_pkg::classify(base_char);

  for (genvar k = 0; k < MAX_MOTIF; k++) begin : g_cell
    logic [PB-1:0] plus_pos;

    assign plus_pos             = PB'(eff_len) - PB'(1) - PB'(k);
    assign sel[k].active        = 32'(eff_len) > k;
    assign sel[k].plus_mask     = imss_pkg::pos_mask(pattern_low, pattern_high, plus_pos);
    assign sel[k].minus_mask    = imss_pkg::pos_mask(pattern_low, pattern_high, PB'(k));

    if (k == 0) begin : g_head
      imss_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (in_fire),
        .clear    (1'b0),
        .shift_in (cls_in),
        .sel      (sel[k]),
        .cls      (win[k]),
        .match    (match[k])
      );
    end else begin : g_body
      imss_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (in_fire),
        .clear    (restart),
        .shift_in (win[k-1]),
        .sel      (sel[k]),
        .cls      (win[k]),
        .match    (match[k])
      );
    end
  end

  logic plus_all;
  logic minus_all;
  logic plus_hit;
  logic minus_hit;

  always_comb begin
    plus_all  = 1'b1;
    minus_all = 1'b1;
    for (int k = 0; k < MAX_MOTIF; k++) begin
      plus_all  = plus_all  && match[k].plus_ok;
      minus_all = minus_all && match[k].minus_ok;
    end
    plus_hit  = plus_all  && (strand_mode != imss_pkg::STRAND_MINUS);
    minus_hit = minus_all && (strand_mode != imss_pkg::STRAND_PLUS);
  end

  // two-deep result queue: hold stage then output stage
  logic          e_valid;
  logic          e_plus;
  logic          e_minus;
  logic [SB-1:0] e_start;
  logic [SB-1:0] e_end;
  logic          o_plus;
  logic          o_minus;
  logic [SB-1:0] o_start;
  logic [SB-1:0] o_end;
  logic          e_load;
  logic          e_move;
  logic          o_done;

  assign out_valid   = o_plus || o_minus;
  assign o_done      = !out_valid || (out_ready && !(o_plus && o_minus));
  assign e_move      = e_valid && o_done;
  assign in_ready    = !e_valid || e_move;
  assign e_load      = in_fire && window_full && region_ok && (plus_hit || minus_hit);

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      o_plus  <= 1'b0;
      o_minus <= 1'b0;
    end else begin
      if (e_load) begin
        e_valid <= 1'b1;
      end else if (e_move) begin
        e_valid <= 1'b0;
      end
      if (e_move) begin
        o_plus  <= e_plus;
        o_minus <= e_minus;
      end else if (out_valid && out_ready) begin
        // plus site goes first
        if (o_plus) begin
          o_plus <= 1'b0;
        end else begin
          o_minus <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (e_load) begin
      e_plus  <= plus_hit;
      e_minus <= minus_hit;
      e_start <= SB'(start);
      e_end   <= SB'(coord);
    end
    if (e_move) begin
      o_start <= e_start;
      o_end   <= e_end;
    end
  end

  assign site_start  = o_start;
  assign site_end    = o_end;
  assign on_minus    = !o_plus;
  assign last_of_run = !(o_plus && o_minus);

endmodule

>>> hw/rtl/imss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scanner window cell
// Holds the class of one window slot, takes its shift input (neighbor's class,
// or the new base at the head; A on clear) on every accepted item and checks
// that class against its plus mask and its complement against its minus mask.
// ----------------------------------------------------------------------------
module imss_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 clear,
  input  imss_pkg::cls_t       shift_in,
  input  imss_pkg::cell_sel_t  sel,
  output imss_pkg::cls_t       cls,
  output imss_pkg::cell_match_t match
);

  imss_pkg::cls_t cls_next;

  assign cls_next = clear ? imss_pkg::CLS_A : shift_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      cls <= imss_pkg::CLS_A;
    end else if (shift) begin
      cls <= cls_next;
    end
  end

  // check the slot as it will be after this shift; slots past the motif pass
  always_comb begin
    match.plus_ok  = !sel.active || imss_pkg::accepts(sel.plus_mask, cls_next);
    match.minus_ok = !sel.active ||
                     imss_pkg::accepts(sel.minus_mask, imss_pkg::complement(cls_next));
  end

endmodule
